// ===== design/mkld_pkg.sv =====
// ----------------------------------------------------------------------------
// mkld_pkg: shared types and constants of the Morse key letter decoder
// Event codes, register indexes, register widths and reset values.
// ----------------------------------------------------------------------------
package mkld_pkg;

  // Event codes carried by a result request
  typedef enum logic [1:0] {
    EV_ELEMENT = 2'd0,
    EV_CORRECT = 2'd1,
    EV_WRONG   = 2'd2,
    EV_HINT    = 2'd3
  } event_kind_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_DOT_MAX     = 3'd0,
    REG_LETTER_GAP  = 3'd1,
    REG_HINT_IDLE   = 3'd2,
    REG_DEBOUNCE    = 3'd3,
    REG_TGT_PATTERN = 3'd4,
    REG_TGT_LENGTH  = 3'd5
  } reg_index_t;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned REL_W      = 8;
  localparam int unsigned OUT_BITS_W = 7;
  localparam int unsigned OUT_CNT_W  = 3;

  // Register reset values
  localparam logic [TICK_W-1:0]     DOT_MAX_RST    = 16'd200;
  localparam logic [TICK_W-1:0]     LETTER_GAP_RST = 16'd600;
  localparam logic [TICK_W-1:0]     HINT_IDLE_RST  = 16'd3500;
  localparam logic [REL_W-1:0]      DEBOUNCE_RST   = 8'd30;
  localparam logic [OUT_BITS_W-1:0] TGT_PAT_RST    = 7'd0;
  localparam logic [OUT_CNT_W-1:0]  TGT_LEN_RST    = 3'd1;

  localparam logic [TICK_W-1:0] TICK_SAT = '1;
  localparam logic [REL_W-1:0]  REL_SAT  = '1;

endpackage

// ===== design/mkld_channels.sv =====
// ----------------------------------------------------------------------------
// mkld channels: valid/ready channels of the Morse key letter decoder
// One channel for key ticks and one for decoder events.
// ----------------------------------------------------------------------------
interface mkld_key_if;
  logic valid;
  logic ready;
  logic key_pressed;

  modport source (output valid, output key_pressed, input ready);
  modport sink   (input valid, input key_pressed, output ready);
endinterface

interface mkld_event_if;
  import mkld_pkg::*;

  logic                  valid;
  logic                  ready;
  event_kind_t           event_kind;
  logic                  element_dash;
  logic [OUT_BITS_W-1:0] entry_bits;
  logic [OUT_CNT_W-1:0]  entry_count;

  modport source (output valid, output event_kind, output element_dash,
                  output entry_bits, output entry_count, input ready);
  modport sink   (input valid, input event_kind, input element_dash,
                  input entry_bits, input entry_count, output ready);
endinterface

// ===== design/morse_key_letter_decoder.sv =====
// ----------------------------------------------------------------------------
// morse_key_letter_decoder: straight key Morse letter decoder
// Times key presses into dots and dashes, collects a letter and judges it
// against a target pattern; reports element, correct, wrong and hint events.
// ----------------------------------------------------------------------------
// Usage:
//   key_in carries one request per millisecond tick with the key level.
//   event_out carries at most one event per tick: element added (with the
//   dot/dash and the entry so far), letter correct, letter wrong, or hint.
//   The cfg port writes the six timing and target registers; write them
//   only while no tick is in flight.
// Timing:
//   A tick is captured in an input register, then decoded in one pass into
//   the state and the event register, which drives event_out. One tick is
//   accepted every cycle while no event waits untaken on event_out; the
//   single decode pass per tick sets that rate.
// Reset:
//   rst clears the key, timer and entry state, empties both registers and
//   loads the register defaults (200, 600, 3500, 30, pattern 0, length 1).
// Stall:
//   While event_out is held, a waiting event stays put and the input
//   register holds one more tick; key_in then drops ready until the event
//   is taken.
// ----------------------------------------------------------------------------
module morse_key_letter_decoder #(
  parameter int unsigned MAX_ELEMENTS = 7
) (
  input  logic                               clk,
  input  logic                               rst,
  mkld_key_if.sink                           key_in,
  mkld_event_if.source                       event_out,
  input  logic                               cfg_write_en,
  input  logic [2:0]                         cfg_index,
  input  logic [mkld_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mkld_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);

  // Configuration registers
  logic [TICK_W-1:0]     dot_max_ticks;
  logic [TICK_W-1:0]     letter_gap_ticks;
  logic [TICK_W-1:0]     hint_idle_ticks;
  logic [REL_W-1:0]      debounce_ticks;
  logic [OUT_BITS_W-1:0] target_pattern;
  logic [OUT_CNT_W-1:0]  target_length;

  // Decoder state
  logic                    key_latched, key_latched_next;
  logic                    release_pending, release_pending_next;
  logic                    hint_given, hint_given_next;
  logic [TICK_W-1:0]       press_ticks, press_ticks_next;
  logic [REL_W-1:0]        release_ticks, release_ticks_next;
  logic [TICK_W-1:0]       idle_ticks, idle_ticks_next;
  logic [MAX_ELEMENTS-1:0] entered_bits, entered_bits_next;
  logic [CNT_W-1:0]        entered_count, entered_count_next;

  // Input and event registers
  logic s1_valid;
  logic s1_key;
  logic s1_fire;
  logic out_valid;
  event_kind_t           out_kind;
  logic                  out_dash;
  logic [OUT_BITS_W-1:0] out_bits;
  logic [OUT_CNT_W-1:0]  out_count;

  // Decode results
  logic                    emit;
  event_kind_t             emit_kind;
  logic                    emit_dash;
  logic [MAX_ELEMENTS-1:0] emit_bits;
  logic [CNT_W-1:0]        emit_count;
  logic [TICK_W:0]         press_sum;
  logic [TICK_W-1:0]       press_v;
  logic [REL_W-1:0]        release_v;
  logic [TICK_W:0]         idle_sum;
  logic [TICK_W-1:0]       idle_inc;
  logic                    dash;
  logic                    mismatch;
  logic [MAX_ELEMENTS+OUT_BITS_W-1:0] tgt_wide;
  logic [MAX_ELEMENTS+OUT_BITS_W-1:0] emit_bits_wide;
  logic [CNT_W+OUT_CNT_W-1:0]         emit_count_wide;

  // Handshake
  assign s1_fire       = s1_valid && (!out_valid || event_out.ready);
  assign key_in.ready  = !s1_valid || s1_fire;

  assign event_out.valid        = out_valid;
  assign event_out.event_kind   = out_kind;
  assign event_out.element_dash = out_dash;
  assign event_out.entry_bits   = out_bits;
  assign event_out.entry_count  = out_count;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_max_ticks    <= DOT_MAX_RST;
      letter_gap_ticks <= LETTER_GAP_RST;
      hint_idle_ticks  <= HINT_IDLE_RST;
      debounce_ticks   <= DEBOUNCE_RST;
      target_pattern   <= TGT_PAT_RST;
      target_length    <= TGT_LEN_RST;
    end else if (cfg_write_en) begin
      case (reg_index_t'(cfg_index))
        REG_DOT_MAX:     dot_max_ticks    <= cfg_data;
        REG_LETTER_GAP:  letter_gap_ticks <= cfg_data;
        REG_HINT_IDLE:   hint_idle_ticks  <= cfg_data;
        REG_DEBOUNCE:    debounce_ticks   <= cfg_data[REL_W-1:0];
        REG_TGT_PATTERN: target_pattern   <= cfg_data[OUT_BITS_W-1:0];
        REG_TGT_LENGTH:  target_length    <= cfg_data[OUT_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturating idle increment
  assign idle_sum = {1'b0, idle_ticks} + (TICK_W+1)'(1);
  assign idle_inc = idle_sum[TICK_W] ? TICK_SAT : idle_sum[TICK_W-1:0];

  assign tgt_wide = {{MAX_ELEMENTS{1'b0}}, target_pattern};

  // Decode one tick
  always_comb begin
    key_latched_next     = key_latched;
    release_pending_next = release_pending;
    hint_given_next      = hint_given;
    press_ticks_next     = press_ticks;
    release_ticks_next   = release_ticks;
    idle_ticks_next      = idle_ticks;
    entered_bits_next    = entered_bits;
    entered_count_next   = entered_count;
    emit       = 1'b0;
    emit_kind  = EV_ELEMENT;
    emit_dash  = 1'b0;
    emit_bits  = '0;
    emit_count = '0;
    press_sum  = '0;
    press_v    = press_ticks;
    release_v  = release_ticks;
    dash       = 1'b0;
    mismatch   = 1'b0;

    if (s1_key) begin
      // Pressed: start an element or extend it, folding in any jitter gap
      if (!key_latched) begin
        key_latched_next = 1'b1;
        press_ticks_next = '0;
        hint_given_next  = 1'b0;
      end else begin
        if (release_pending) begin
          press_sum = {1'b0, press_ticks} + (TICK_W+1)'(release_ticks)
                      + (TICK_W+1)'(1);
        end else begin
          press_sum = {1'b0, press_ticks} + (TICK_W+1)'(1);
        end
        press_ticks_next = press_sum[TICK_W] ? TICK_SAT : press_sum[TICK_W-1:0];
      end
      release_pending_next = 1'b0;
      idle_ticks_next      = '0;
    end else if (key_latched) begin
      // Released: count debounce, then close the element
      if (!release_pending) begin
        release_pending_next = 1'b1;
        release_v = '0;
        press_sum = {1'b0, press_ticks} + (TICK_W+1)'(1);
        press_v   = press_sum[TICK_W] ? TICK_SAT : press_sum[TICK_W-1:0];
      end else if (release_ticks != REL_SAT) begin
        release_v = release_ticks + REL_W'(1);
      end
      release_ticks_next = release_v;
      press_ticks_next   = press_v;
      if (release_v >= debounce_ticks) begin
        dash = (press_v >= dot_max_ticks);
        key_latched_next     = 1'b0;
        release_pending_next = 1'b0;
        idle_ticks_next      = '0;
        if (entered_count < CNT_W'(MAX_ELEMENTS)) begin
          entered_bits_next  = entered_bits | (MAX_ELEMENTS'(dash) << entered_count);
          entered_count_next = entered_count + CNT_W'(1);
          emit       = 1'b1;
          emit_kind  = EV_ELEMENT;
          emit_dash  = dash;
          emit_bits  = entered_bits_next;
          emit_count = entered_count_next;
        end
      end else begin
        idle_ticks_next = idle_inc;
      end
    end else begin
      idle_ticks_next = idle_inc;
    end

    // Judge the letter after a long enough gap
    if (!emit && !key_latched_next && (entered_count_next != '0) &&
        (idle_ticks_next > letter_gap_ticks)) begin
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
        if (i < int'(entered_count_next)) begin
          mismatch = mismatch | (entered_bits_next[i] ^ tgt_wide[i]);
        end
      end
      emit       = 1'b1;
      emit_kind  = (!mismatch && (entered_count_next == CNT_W'(target_length))) ?
                   EV_CORRECT : EV_WRONG;
      emit_bits  = entered_bits_next;
      emit_count = entered_count_next;
      entered_bits_next  = '0;
      entered_count_next = '0;
      idle_ticks_next    = '0;
      hint_given_next    = 1'b0;
    end

    // Give one hint after a long idle with nothing entered
    if (!emit && !key_latched_next && (entered_count_next == '0) && !hint_given_next &&
        (idle_ticks_next > hint_idle_ticks)) begin
      emit            = 1'b1;
      emit_kind       = EV_HINT;
      hint_given_next = 1'b1;
      idle_ticks_next = '0;
    end
  end

  assign emit_bits_wide  = {{OUT_BITS_W{1'b0}}, emit_bits};
  assign emit_count_wide = {{OUT_CNT_W{1'b0}}, emit_count};

  // Capture the tick request
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (key_in.valid && key_in.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (key_in.valid && key_in.ready) begin
      s1_key <= key_in.key_pressed;
    end
  end

  // Advance decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      key_latched     <= 1'b0;
      release_pending <= 1'b0;
      hint_given      <= 1'b0;
      press_ticks     <= '0;
      release_ticks   <= '0;
      idle_ticks      <= '0;
      entered_bits    <= '0;
      entered_count   <= '0;
    end else if (s1_fire) begin
      key_latched     <= key_latched_next;
      release_pending <= release_pending_next;
      hint_given      <= hint_given_next;
      press_ticks     <= press_ticks_next;
      release_ticks   <= release_ticks_next;
      idle_ticks      <= idle_ticks_next;
      entered_bits    <= entered_bits_next;
      entered_count   <= entered_count_next;
    end
  end

  // Load or drop the event register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && emit) begin
      out_valid <= 1'b1;
    end else if (event_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      out_kind  <= emit_kind;
      out_dash  <= emit_dash;
      out_bits  <= emit_bits_wide[OUT_BITS_W-1:0];
      out_count <= emit_count_wide[OUT_CNT_W-1:0];
    end
  end

  // Checks on decoder state and events
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entered_count <= CNT_W'(MAX_ELEMENTS))
    else $error("entry count above capacity");

  a_pending_latched: assert property (@(posedge clk) disable iff (rst)
    release_pending |-> key_latched)
    else $error("release pending without a latched key");

  a_hint_empty: assert property (@(posedge clk) disable iff (rst)
    hint_given |-> (entered_count == '0))
    else $error("hint flag set with a non-empty entry");

  a_hint_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == EV_HINT)) |-> ((out_bits == '0) && (out_count == '0)))
    else $error("hint event carries an entry");

  a_event_source: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(s1_fire))
    else $error("event appeared without a decoded tick");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench of the Morse key letter decoder
// Feeds key ticks through the valid/ready channel and keeps a cycle-free
// copy of the decoder state to predict every event. Each event is checked
// field by field. Runs directed letters, register extremes and random
// letters under several idle and stall mixes and register settings.
// ----------------------------------------------------------------------------
module tb;
  import mkld_pkg::*;

  localparam int unsigned MAX_ELEMENTS = 7;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct {
    event_kind_t           kind;
    logic                  dash;
    logic [OUT_BITS_W-1:0] bits;
    logic [OUT_CNT_W-1:0]  count;
  } decoder_event_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write_en = 1'b0;
  logic [2:0]            cfg_index = REG_DOT_MAX;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mkld_key_if   key_ch ();
  mkld_event_if ev_ch ();

  morse_key_letter_decoder #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .key_in      (key_ch),
    .event_out   (ev_ch),
    .cfg_write_en(cfg_write_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // Pending key ticks and the events they are predicted to cause
  logic           key_ticks[$];
  decoder_event_t awaited_events[$];
  int unsigned    ticks_pushed = 0;
  int unsigned    mismatch_count = 0;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;

  // Register mirror
  logic [TICK_W-1:0]     cfg_dot_max = DOT_MAX_RST;
  logic [TICK_W-1:0]     cfg_gap = LETTER_GAP_RST;
  logic [TICK_W-1:0]     cfg_hint = HINT_IDLE_RST;
  logic [REL_W-1:0]      cfg_debounce = DEBOUNCE_RST;
  logic [OUT_BITS_W-1:0] cfg_pattern = TGT_PAT_RST;
  logic [OUT_CNT_W-1:0]  cfg_len = TGT_LEN_RST;

  // Decoder state mirror
  logic                  m_latched = 1'b0;
  logic                  m_rel_pending = 1'b0;
  logic                  m_hint_given = 1'b0;
  logic [TICK_W-1:0]     m_press = '0;
  logic [REL_W-1:0]      m_release = '0;
  logic [TICK_W-1:0]     m_idle = '0;
  logic [OUT_BITS_W-1:0] m_bits = '0;
  logic [OUT_CNT_W-1:0]  m_count = '0;

  initial forever #10 clk = ~clk;

  initial begin
    key_ch.valid       = 1'b0;
    key_ch.key_pressed = 1'b0;
    ev_ch.ready        = 1'b0;
  end

  // Advance the decoder mirror by one tick and queue the event it causes
  task automatic decode_tick(input logic key);
    logic [17:0]    sum;
    logic           dash;
    logic           ok;
    logic [7:0]     mask;
    logic           emitted;
    decoder_event_t ev;
    emitted = 1'b0;
    if (key) begin
      if (!m_latched) begin
        m_latched    = 1'b1;
        m_press      = '0;
        m_hint_given = 1'b0;
      end else begin
        // a renewed press during debounce counts the released ticks too
        sum = m_press + (m_rel_pending ? m_release + 18'd1 : 18'd1);
        m_press = (sum > TICK_SAT) ? TICK_SAT : sum[TICK_W-1:0];
      end
      m_rel_pending = 1'b0;
      m_idle        = '0;
    end else if (m_latched) begin
      if (!m_rel_pending) begin
        m_rel_pending = 1'b1;
        m_release     = '0;
        sum = m_press + 18'd1;
        m_press = (sum > TICK_SAT) ? TICK_SAT : sum[TICK_W-1:0];
      end else if (m_release < REL_SAT) begin
        m_release++;
      end
      if (m_release >= cfg_debounce) begin
        dash = (m_press < cfg_dot_max) ? 1'b0 : 1'b1;
        m_latched     = 1'b0;
        m_rel_pending = 1'b0;
        m_idle        = '0;
        // drop elements once the entry is full
        if (m_count < MAX_ELEMENTS) begin
          m_bits[m_count] = m_bits[m_count] | dash;
          m_count++;
          ev = '{EV_ELEMENT, dash, m_bits, m_count};
          awaited_events.push_back(ev);
          emitted = 1'b1;
        end
      end else if (m_idle != TICK_SAT) begin
        m_idle++;
      end
    end else if (m_idle != TICK_SAT) begin
      m_idle++;
    end

    // Judge the letter after the gap
    if (!emitted && !m_latched && m_count > 0 && m_idle > cfg_gap) begin
      mask = (8'd1 << m_count) - 8'd1;
      ok = (m_count == cfg_len) &&
           ((m_bits & mask[OUT_BITS_W-1:0]) == (cfg_pattern & mask[OUT_BITS_W-1:0]));
      ev = '{ok ? EV_CORRECT : EV_WRONG, 1'b0, m_bits, m_count};
      awaited_events.push_back(ev);
      emitted      = 1'b1;
      m_bits       = '0;
      m_count      = '0;
      m_idle       = '0;
      m_hint_given = 1'b0;
    end

    // Give one hint after a long idle with nothing entered
    if (!emitted && !m_latched && m_count == 0 && !m_hint_given && m_idle > cfg_hint) begin
      ev = '{EV_HINT, 1'b0, '0, '0};
      awaited_events.push_back(ev);
      m_hint_given = 1'b1;
      m_idle       = '0;
    end
  endtask

  // Drive ticks from the queue; predict each accepted request
  always @(posedge clk) begin
    if (rst) begin
      key_ch.valid <= 1'b0;
    end else begin
      if (key_ch.valid && key_ch.ready) begin
        decode_tick(key_ch.key_pressed);
      end
      if (!key_ch.valid || key_ch.ready) begin
        if (key_ticks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          key_ch.valid       <= 1'b1;
          key_ch.key_pressed <= key_ticks.pop_front();
        end else begin
          key_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Stall the event channel at random; check each event request
  always @(posedge clk) begin : event_monitor
    decoder_event_t want;
    if (rst) begin
      ev_ch.ready <= 1'b0;
    end else begin
      ev_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (ev_ch.valid && ev_ch.ready) begin
        if (awaited_events.size() == 0) begin
          $error("unexpected event: event_kind %0d", ev_ch.event_kind);
          mismatch_count++;
        end else begin
          want = awaited_events.pop_front();
          if (ev_ch.event_kind !== want.kind) begin
            $error("event_kind: expected %0d, got %0d", want.kind, ev_ch.event_kind);
            mismatch_count++;
          end
          if (ev_ch.element_dash !== want.dash) begin
            $error("element_dash: expected %0d, got %0d", want.dash, ev_ch.element_dash);
            mismatch_count++;
          end
          if (ev_ch.entry_bits !== want.bits) begin
            $error("entry_bits: expected 0x%02h, got 0x%02h", want.bits, ev_ch.entry_bits);
            mismatch_count++;
          end
          if (ev_ch.entry_count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, ev_ch.entry_count);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Write one register and update the mirror
  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    case (idx)
      REG_DOT_MAX:     cfg_dot_max = data[TICK_W-1:0];
      REG_LETTER_GAP:  cfg_gap = data[TICK_W-1:0];
      REG_HINT_IDLE:   cfg_hint = data[TICK_W-1:0];
      REG_DEBOUNCE:    cfg_debounce = data[REL_W-1:0];
      REG_TGT_PATTERN: cfg_pattern = data[OUT_BITS_W-1:0];
      REG_TGT_LENGTH:  cfg_len = data[OUT_CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [15:0] dot_max, input logic [15:0] gap,
                              input logic [15:0] hint, input logic [7:0] debounce,
                              input logic [6:0] pattern, input logic [2:0] len);
    write_reg(REG_DOT_MAX, dot_max);
    write_reg(REG_LETTER_GAP, gap);
    write_reg(REG_HINT_IDLE, hint);
    write_reg(REG_DEBOUNCE, {8'd0, debounce});
    write_reg(REG_TGT_PATTERN, {9'd0, pattern});
    write_reg(REG_TGT_LENGTH, {13'd0, len});
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // Hold until every tick is sent and every event has come, then let the
  // pipeline empty
  task automatic wait_drained();
    do @(negedge clk);
    while (key_ticks.size() > 0 || key_ch.valid || awaited_events.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_level(input logic level, input int unsigned n);
    repeat (n) key_ticks.push_back(level);
    ticks_pushed += n;
  endtask

  // One keyed element, sometimes with jitter inside the press
  task automatic push_element(input logic want_dash);
    int unsigned len;
    int unsigned split;
    if (want_dash || cfg_dot_max < 2) begin
      len = cfg_dot_max + $urandom_range(0, 3);
    end else begin
      len = $urandom_range(1, cfg_dot_max - 1);
    end
    if (cfg_debounce > 0 && len >= 2 && $urandom_range(3) == 0) begin
      split = $urandom_range(1, len - 1);
      push_level(1'b1, split);
      push_level(1'b0, $urandom_range(1, cfg_debounce));
      push_level(1'b1, len - split);
    end else begin
      push_level(1'b1, len);
    end
    push_level(1'b0, cfg_debounce + 1);
  endtask

  // One letter, often the target itself, ended by a letter gap
  task automatic push_letter();
    int unsigned n;
    logic        match;
    match = ($urandom_range(2) == 0);
    n = match ? cfg_len : $urandom_range(1, 9);
    if (n == 0) n = 1;
    for (int i = 0; i < n; i++) begin
      push_element((match && i < OUT_BITS_W) ? cfg_pattern[i] : 1'($urandom_range(1)));
      if (i < n - 1) push_level(1'b0, $urandom_range(0, cfg_gap));
    end
    push_level(1'b0, cfg_gap + 1 + $urandom_range(0, 2));
    if ($urandom_range(5) == 0) push_level(1'b0, cfg_hint + 2);
  endtask

  // Random letters and noise under one idle mix, with a pause midway
  task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                  input int unsigned n_ticks);
    int unsigned start;
    logic        paused;
    apply_config(16'($urandom_range(2, 6)), 16'($urandom_range(3, 12)),
                 16'($urandom_range(8, 40)), 8'($urandom_range(0, 3)),
                 7'($urandom_range(0, 127)), 3'($urandom_range(1, 7)));
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start  = ticks_pushed;
    paused = 1'b0;
    while (ticks_pushed - start < n_ticks) begin
      if ($urandom_range(7) == 0) begin
        repeat ($urandom_range(1, 12)) push_level(1'($urandom_range(1)), 1);
      end else begin
        push_letter();
      end
      if (!paused && ticks_pushed - start >= n_ticks / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Hint, then a correct dot-dash-dot with no debounce
    apply_config(16'd2, 16'd3, 16'd5, 8'd0, 7'b0000010, 3'd3);
    push_level(1'b0, 7);
    push_level(1'b1, 1); push_level(1'b0, 2);
    push_level(1'b1, 3); push_level(1'b0, 2);
    push_level(1'b1, 1); push_level(1'b0, 5);
    wait_drained();

    // Full entry of dashes with jitter; the eighth element is dropped
    apply_config(16'd1, 16'd2, 16'd40, 8'd2, 7'h7F, 3'd7);
    push_level(1'b1, 2); push_level(1'b0, 2); push_level(1'b1, 1); push_level(1'b0, 3);
    push_level(1'b1, 1); push_level(1'b0, 1); push_level(1'b1, 1); push_level(1'b0, 3);
    repeat (6) begin
      push_level(1'b1, 1); push_level(1'b0, 3);
    end
    push_level(1'b0, 3);
    wait_drained();

    // Zero gap and hint; zero target length makes any letter wrong
    apply_config(16'd3, 16'd0, 16'd0, 8'd0, 7'd0, 3'd0);
    push_level(1'b1, 1);
    push_level(1'b0, 4);
    wait_drained();

    // Keep the hint out of reach, then lower it under the idle count
    apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 7'd1, 3'd1);
    push_level(1'b0, 100);
    wait_drained();
    apply_config(16'hFFFF, 16'hFFFF, 16'd1, 8'hFF, 7'd1, 3'd1);
    push_level(1'b0, 1);
    // a dot under the widest dot limit, closed by the longest debounce
    push_level(1'b1, 20);
    push_level(1'b0, 256);
    wait_drained();
    apply_config(16'hFFFF, 16'd1, 16'd1, 8'hFF, 7'd1, 3'd1);
    push_level(1'b0, 3);
    wait_drained();

    // Random letters under each idle mix
    run_random_phase(0, 0, 220);
    run_random_phase(77, 0, 220);
    run_random_phase(0, 77, 220);
    run_random_phase(14, 14, 220);

    if (mismatch_count == 0 && awaited_events.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
